FILE: hdl/address_pool_binding_table_unit_assert.svh
// assertion macros for the address pool binding table
`ifndef ADDRESS_POOL_BINDING_TABLE_UNIT_ASSERT_SVH
`define ADDRESS_POOL_BINDING_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define APBT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apbt assertion failed");

// next-cycle implication, checked out of reset
`define APBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apbt assertion failed");

`endif

FILE: hdl/apbt_pkg.sv
package apbt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    // ascii "000000" marks an entry with no client
    localparam logic [47:0] UNBOUND_HW = 48'h303030303030;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_SEARCH = 3'd2,
        ACT_CHECK  = 3'd3,
        ACT_BIND   = 3'd4,
        ACT_UNBIND = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EXISTS = 3'd1,
        ST_ABSENT = 3'd2,
        ST_FULL   = 3'd3,
        ST_NOFREE = 3'd4
    } status_t;

    typedef struct packed {
        action_t     action;
        logic [47:0] hw_addr;
        logic [31:0] ip_addr;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] found_addr;
        logic        conflict;
    } rsp_t;

    // update applied by every cell on commit
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_APPEND   = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_SET_HW   = 3'd3,
        OP_CLEAR_HW = 3'd4
    } cell_op_t;

    typedef struct packed {
        logic     commit;
        cell_op_t op;
    } cmd_t;

    // flags rippled from lower to higher cells
    typedef struct packed {
        logic ip_seen;
        logic hw_seen;
        logic free_seen;
        logic conf_seen;
        logic occ;
    } chain_t;

    // entry handed from a cell to its lower neighbour on delete
    typedef struct packed {
        logic        occ;
        logic [31:0] ip;
        logic [47:0] hw;
    } entry_t;

    // per-cell report collected by the controller
    typedef struct packed {
        logic        first_ip;
        logic        clash;
        logic [31:0] hw_pick;
        logic [31:0] free_pick;
    } cell_rpt_t;

endpackage

FILE: hdl/address_pool_binding_table_unit.sv
// result: an accepted request is registered, matched over the row of cells, and its result
//   is written to the result register once that register has room
// accept: no new request is taken until the current one has committed; the commit waits
//   while the result register is stalled
// reset: rst_n async active low empties the table and drops any pending result;
//   entry contents are not cleared and are never read before being written
`include "address_pool_binding_table_unit_assert.svh"

module address_pool_binding_table_unit #(
    parameter int TABLE_DEPTH = apbt_pkg::TABLE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  apbt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output apbt_pkg::rsp_t rsp
);
    import apbt_pkg::*;

    // two-state sequencer, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } state_t;

    state_t    state_reg;
    state_t    state_next;

    // request held for the whole match pass
    req_t      req_reg;
    req_t      req_next;

    // result register, parts the output side from the cells
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    rsp_t      rsp_reg;
    rsp_t      rsp_next;

    cmd_t      cmd;
    rsp_t      result;

    // chain links: element i feeds cell i, element i+1 leaves it
    chain_t    chain_w [TABLE_DEPTH+1];
    // entries: element i is cell i, top element is an empty filler
    entry_t    ent_w   [TABLE_DEPTH+1];
    cell_rpt_t rpt_w   [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] occ_vec;
    logic [TABLE_DEPTH-1:0] first_ip_vec;
    logic                   clash_any;
    logic [31:0]            hw_pick_any;
    logic [31:0]            free_pick_any;

    logic any_ip;
    logic any_hw;
    logic any_free;
    logic any_conf;
    logic full;
    logic can_commit;

    // bottom of the chain looks like an occupied slot with no hits so
    // that cell 0 is the tail of an empty table
    assign chain_w[0] = '{ip_seen: 1'b0, hw_seen: 1'b0, free_seen: 1'b0,
                          conf_seen: 1'b0, occ: 1'b1};
    assign ent_w[TABLE_DEPTH] = '{occ: 1'b0, ip: '0, hw: '0};

    // ---------------------------------------------------------------
    // row of cells
    // ---------------------------------------------------------------
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        apbt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .req       (req_reg),
            .cmd       (cmd),
            .chain_in  (chain_w[i]),
            .chain_out (chain_w[i+1]),
            .nbr_in    (ent_w[i+1]),
            .entry_out (ent_w[i]),
            .rpt       (rpt_w[i])
        );
    end

    // ---------------------------------------------------------------
    // gather the cell reports; at most one cell reports each pick
    // ---------------------------------------------------------------
    always_comb
    begin
        clash_any     = 1'b0;
        hw_pick_any   = '0;
        free_pick_any = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            occ_vec[i]      = chain_w[i+1].occ;
            first_ip_vec[i] = rpt_w[i].first_ip;
            clash_any       = clash_any | rpt_w[i].clash;
            hw_pick_any     = hw_pick_any | rpt_w[i].hw_pick;
            free_pick_any   = free_pick_any | rpt_w[i].free_pick;
        end
    end

    assign any_ip   = chain_w[TABLE_DEPTH].ip_seen;
    assign any_hw   = chain_w[TABLE_DEPTH].hw_seen;
    assign any_free = chain_w[TABLE_DEPTH].free_seen;
    assign any_conf = chain_w[TABLE_DEPTH].conf_seen;
    assign full     = chain_w[TABLE_DEPTH].occ;

    // commit only once the result register has room
    assign can_commit = (state_reg == S_BUSY) && (!rsp_valid_reg || rsp_ready);

    // ---------------------------------------------------------------
    // decide status and the update every cell applies
    // ---------------------------------------------------------------
    always_comb
    begin
        result     = '{status: ST_OK, found_addr: '0, conflict: 1'b0};
        cmd.commit = can_commit;
        cmd.op     = OP_NONE;
        case (req_reg.action)
            ACT_ADD:
            begin
                if (any_ip)
                begin
                    result.status = ST_EXISTS;
                end
                else if (full)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    cmd.op = OP_APPEND;
                end
            end
            ACT_DELETE:
            begin
                if (!any_ip)
                begin
                    result.status = ST_ABSENT;
                end
                else
                begin
                    cmd.op = OP_REMOVE;
                end
            end
            ACT_SEARCH:
            begin
                // client's own binding first, then the first free entry
                if (any_hw)
                begin
                    result.found_addr = hw_pick_any;
                end
                else if (any_free)
                begin
                    result.found_addr = free_pick_any;
                end
                else
                begin
                    result.status = ST_NOFREE;
                end
            end
            ACT_CHECK:
            begin
                result.conflict = any_conf;
            end
            ACT_BIND:
            begin
                if (!any_ip)
                begin
                    result.status = ST_ABSENT;
                end
                else if (clash_any)
                begin
                    result.status = ST_EXISTS;
                end
                else
                begin
                    cmd.op = OP_SET_HW;
                end
            end
            ACT_UNBIND:
            begin
                // bound to some other client reads as not present
                if (!any_ip || clash_any)
                begin
                    result.status = ST_ABSENT;
                end
                else
                begin
                    cmd.op = OP_CLEAR_HW;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer and result register
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (can_commit)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = result;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // occupied cells always form an unbroken run from cell 0
    `APBT_ASSERT_NOW(a_occ_thermo, 1'b1, $onehot({1'b0, occ_vec} + 1'b1))
    // an address is found in at most one place first
    `APBT_ASSERT_NOW(a_first_ip_unique, 1'b1, $onehot0(first_ip_vec))
    // an append grows the table by one entry
    `APBT_ASSERT_NEXT(a_append_grows, cmd.commit && cmd.op == OP_APPEND,
        $countones(occ_vec) == $past($countones(occ_vec)) + 1)
    // a removal shrinks the table by one entry
    `APBT_ASSERT_NEXT(a_remove_shrinks, cmd.commit && cmd.op == OP_REMOVE,
        $countones(occ_vec) + 1 == $past($countones(occ_vec)))

endmodule

FILE: hdl/apbt_cell.sv
module apbt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  apbt_pkg::req_t     req,
    input  apbt_pkg::cmd_t     cmd,
    input  apbt_pkg::chain_t   chain_in,
    output apbt_pkg::chain_t   chain_out,
    input  apbt_pkg::entry_t   nbr_in,
    output apbt_pkg::entry_t   entry_out,
    output apbt_pkg::cell_rpt_t rpt
);
    import apbt_pkg::*;

    logic        occ_reg;
    logic        occ_next;
    logic [31:0] ip_reg;
    logic [31:0] ip_next;
    logic [47:0] hw_reg;
    logic [47:0] hw_next;

    logic ip_eq;
    logic hw_eq;
    logic unb;
    logic ip_hit;
    logic hw_hit;
    logic free_hit;
    logic conf_hit;
    logic first_ip;
    logic first_hw;
    logic first_free;

    assign ip_eq    = (ip_reg == req.ip_addr);
    assign hw_eq    = (hw_reg == req.hw_addr);
    assign unb      = (hw_reg == UNBOUND_HW);
    assign ip_hit   = occ_reg & ip_eq;
    assign hw_hit   = occ_reg & hw_eq;
    assign free_hit = occ_reg & unb;
    assign conf_hit = occ_reg & ~unb & (hw_eq ^ ip_eq);

    assign first_ip   = ip_hit & ~chain_in.ip_seen;
    assign first_hw   = hw_hit & ~chain_in.hw_seen;
    assign first_free = free_hit & ~chain_in.free_seen;

    assign chain_out.ip_seen   = chain_in.ip_seen | ip_hit;
    assign chain_out.hw_seen   = chain_in.hw_seen | hw_hit;
    assign chain_out.free_seen = chain_in.free_seen | free_hit;
    assign chain_out.conf_seen = chain_in.conf_seen | conf_hit;
    assign chain_out.occ       = occ_reg;

    assign entry_out.occ = occ_reg;
    assign entry_out.ip  = ip_reg;
    assign entry_out.hw  = hw_reg;

    assign rpt.first_ip  = first_ip;
    assign rpt.clash     = first_ip & ~unb & ~hw_eq;
    assign rpt.hw_pick   = first_hw ? ip_reg : '0;
    assign rpt.free_pick = first_free ? ip_reg : '0;

    always_comb
    begin
        occ_next = occ_reg;
        ip_next  = ip_reg;
        hw_next  = hw_reg;
        if (cmd.commit)
        begin
            case (cmd.op)
                OP_APPEND:
                begin
                    // tail slot: empty, lower neighbour occupied
                    if (!occ_reg && chain_in.occ)
                    begin
                        occ_next = 1'b1;
                        ip_next  = req.ip_addr;
                        hw_next  = UNBOUND_HW;
                    end
                end
                OP_REMOVE:
                begin
                    // at or above the removed entry, pull from above
                    if (chain_in.ip_seen || ip_hit)
                    begin
                        occ_next = nbr_in.occ;
                        ip_next  = nbr_in.ip;
                        hw_next  = nbr_in.hw;
                    end
                end
                OP_SET_HW:
                begin
                    if (first_ip)
                    begin
                        hw_next = req.hw_addr;
                    end
                end
                OP_CLEAR_HW:
                begin
                    if (first_ip)
                    begin
                        hw_next = UNBOUND_HW;
                    end
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg <= ip_next;
        hw_reg <= hw_next;
    end

endmodule
